>>> design/rvx_pkg.sv
// rvx_pkg: types and constants shared by the rv32i execute core
// request and response payloads, opcode and funct3 codes, writeback control
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rvx_pkg;

  localparam logic [1:0] REQ_EXEC    = 2'd0;
  localparam logic [1:0] REQ_PRELOAD = 2'd1;
  localparam logic [1:0] REQ_READ    = 2'd2;
  localparam logic [1:0] REQ_UNUSED  = 2'd3;

  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_ALUIMM = 7'h13;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_ALUREG = 7'h33;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  localparam logic [2:0] F3_LB  = 3'd0;
  localparam logic [2:0] F3_LH  = 3'd1;
  localparam logic [2:0] F3_LW  = 3'd2;
  localparam logic [2:0] F3_LBU = 3'd4;
  localparam logic [2:0] F3_LHU = 3'd5;

  localparam logic [2:0] F3_SB = 3'd0;
  localparam logic [2:0] F3_SH = 3'd1;
  localparam logic [2:0] F3_SW = 3'd2;

  localparam logic [2:0] F3_JALR = 3'd0;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] instruction;
    logic [11:0] mem_word_index;
    logic [31:0] mem_word_data;
    logic [4:0]  reg_index;
  } req_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic [31:0] read_value;
    logic        branch_taken;
    logic        illegal;
  } rsp_t;

  typedef struct packed {
    logic        is_load;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [1:0]  boff;
    logic [31:0] val;
  } wb_t;

endpackage

`default_nettype wire

>>> design/rvx_stream_if.sv
// rvx_req_if and rvx_rsp_if: valid/ready channels for requests and responses
// depends on rvx_pkg
`timescale 1ns / 1ps
`default_nettype none

interface rvx_req_if;
  import rvx_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface rvx_rsp_if;
  import rvx_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

>>> design/rvx_ram.sv
// rvx_ram: generic ram, one write port with byte enables, one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module rvx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [WIDTH/8-1:0]       be,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      for (int b = 0; b < WIDTH / 8; b++) begin
        if (be[b]) begin
          mem[waddr][b*8 +: 8] <= wdata[b*8 +: 8];
        end
      end
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> design/rvx_alu.sv
// rvx_alu: integer alu and branch condition unit
// depends on rvx_pkg
`timescale 1ns / 1ps
`default_nettype none

module rvx_alu (
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  input  wire logic [2:0]  f3,
  input  wire logic        alt,
  output      logic [31:0] y,
  output      logic        cond
);
  import rvx_pkg::*;

  logic lt_s;
  logic lt_u;

  assign lt_s = $signed(a) < $signed(b);
  assign lt_u = a < b;

  always_comb begin
    case (f3)
      F3_ADD:  y = alt ? a - b : a + b;
      F3_SLL:  y = a << b[4:0];
      F3_SLT:  y = {31'd0, lt_s};
      F3_SLTU: y = {31'd0, lt_u};
      F3_XOR:  y = a ^ b;
      F3_SR:   y = alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
      F3_OR:   y = a | b;
      default: y = a & b;
    endcase
  end

  always_comb begin
    case (f3)
      F3_BEQ:  cond = a == b;
      F3_BNE:  cond = a != b;
      F3_BLT:  cond = lt_s;
      F3_BGE:  cond = !lt_s;
      F3_BLTU: cond = lt_u;
      F3_BGEU: cond = !lt_u;
      default: cond = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

>>> design/rvx_load_align.sv
// rvx_load_align: picks and extends the loaded byte, halfword or word
// depends on rvx_pkg
`timescale 1ns / 1ps
`default_nettype none

module rvx_load_align (
  input  wire logic [2:0]  f3,
  input  wire logic [1:0]  boff,
  input  wire logic [31:0] word,
  output      logic [31:0] value
);
  import rvx_pkg::*;

  logic [31:0] shifted;
  logic [15:0] half;

  assign shifted = word >> {boff, 3'b000};
  assign half    = boff[1] ? word[31:16] : word[15:0];

  always_comb begin
    case (f3)
      F3_LB:   value = {{24{shifted[7]}}, shifted[7:0]};
      F3_LH:   value = {{16{half[15]}}, half};
      F3_LBU:  value = {24'd0, shifted[7:0]};
      F3_LHU:  value = {16'd0, half};
      default: value = word;
    endcase
  end

endmodule

`default_nettype wire

>>> design/rv32i_execute_core_unit.sv
// rv32i_execute_core_unit: single-issue rv32i core, one request per cycle while responses are not stalled
// an accepted request is registered into the execute stage, and its response is then registered at the output
// throughput: one request per cycle unless rsp.ready stalls; loads write back from the writeback stage, forwarded
// reset: pc and register file read as zero at once, data memory is undefined
// until preloaded; no clearing pass
// depends on rvx_pkg, rvx_stream_if, rvx_ram, rvx_alu, rvx_load_align
`timescale 1ns / 1ps
`default_nettype none

module rv32i_execute_core_unit #(
  parameter int DATA_WORDS = 4096
) (
  input wire logic clk,
  input wire logic rst,
  rvx_req_if.sink  req,
  rvx_rsp_if.source rsp
);
  import rvx_pkg::*;

  localparam int AW = $clog2(DATA_WORDS);

  // execute stage
  logic        e_valid;
  req_t        e_req;
  logic        e_fire;
  logic        e_held;
  logic [31:0] hold_a;
  logic [31:0] hold_b;
  logic        rv1;
  logic        rv2;
  logic        byp1;
  logic        byp2;
  logic [31:0] byp_val;
  logic [31:0] q1;
  logic [31:0] q2;

  // writeback stage
  logic        m_valid;
  wb_t         m;
  logic [31:0] m_val;
  logic [31:0] ld_val;
  logic [31:0] dq;

  logic [31:0] regvalid;
  logic [31:0] pc;
  logic        o_valid;
  rsp_t        o_data;

  logic        in_fire;
  logic [4:0]  ra1;
  logic [4:0]  ra2;

  logic [31:0] ins;
  logic [6:0]  opc;
  logic [2:0]  f3;
  logic [4:0]  rd;
  logic [4:0]  rs1;
  logic [4:0]  rs2;
  logic [31:0] src_a;
  logic [31:0] src_b;
  logic [31:0] imm_i;
  logic [31:0] imm_s;
  logic [31:0] imm_b;
  logic [31:0] imm_j;
  logic [31:0] imm_u;
  logic [31:0] alu_b;
  logic        alu_alt;
  logic [31:0] alu_y;
  logic        cond;
  logic [31:0] addr;
  logic [31:0] pc4;
  logic [31:0] tgt_imm;
  logic [31:0] tgt;
  logic        legal;
  logic        wen;
  logic [31:0] wval;
  logic        is_ld;
  logic        is_st;
  logic        jump;
  logic        br;
  logic        is_exec;
  logic        do_ins;
  logic        wen_fin;
  logic [31:0] next;

  logic [AW-1:0] widx;
  logic [AW-1:0] pidx;
  logic          d_we;
  logic [3:0]    d_be;
  logic [AW-1:0] d_waddr;
  logic [31:0]   d_wdata;
  logic [3:0]    st_be;
  logic [31:0]   st_data;

  assign in_fire   = req.valid && req.ready;
  assign e_fire    = e_valid && (!o_valid || rsp.ready);
  assign req.ready = !e_valid || e_fire;
  assign rsp.valid = o_valid;
  assign rsp.data  = o_data;

  assign ra1 = (req.data.req_type == REQ_READ) ? req.data.reg_index
                                               : req.data.instruction[19:15];
  assign ra2 = req.data.instruction[24:20];

  // register file, two read copies
  rvx_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
    .clk(clk), .we(m_valid), .be(4'hF), .waddr(m.rd), .wdata(m_val),
    .re(in_fire), .raddr(ra1), .rdata(q1)
  );

  rvx_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
    .clk(clk), .we(m_valid), .be(4'hF), .waddr(m.rd), .wdata(m_val),
    .re(in_fire), .raddr(ra2), .rdata(q2)
  );

  rvx_load_align u_align (.f3(m.f3), .boff(m.boff), .word(dq), .value(ld_val));

  assign m_val = m.is_load ? ld_val : m.val;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid  <= 1'b0;
      e_held   <= 1'b0;
      m_valid  <= 1'b0;
      o_valid  <= 1'b0;
      regvalid <= '0;
      pc       <= '0;
    end else begin
      if (in_fire) begin
        e_valid <= 1'b1;
      end else if (e_fire) begin
        e_valid <= 1'b0;
      end
      e_held  <= e_valid && !e_fire;
      m_valid <= e_fire && wen_fin;
      if (e_fire) begin
        o_valid <= 1'b1;
      end else if (rsp.ready) begin
        o_valid <= 1'b0;
      end
      if (m_valid) begin
        regvalid[m.rd] <= 1'b1;
      end
      if (e_fire && do_ins) begin
        pc <= next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      e_req   <= req.data;
      rv1     <= regvalid[ra1];
      rv2     <= regvalid[ra2];
      byp1    <= m_valid && (m.rd == ra1);
      byp2    <= m_valid && (m.rd == ra2);
      byp_val <= m_val;
    end
    if (e_valid && !e_fire) begin
      hold_a <= src_a;
      hold_b <= src_b;
    end
    if (e_fire) begin
      o_data.next_pc      <= do_ins ? next : pc;
      o_data.read_value   <= (e_req.req_type == REQ_READ) ? src_a : 32'd0;
      o_data.branch_taken <= do_ins && (jump || (br && cond));
      o_data.illegal      <= is_exec && !legal;
      m.is_load <= is_ld;
      m.rd      <= rd;
      m.f3      <= f3;
      m.boff    <= addr[1:0];
      m.val     <= wval;
    end
  end

  // operand selection with forwarding
  assign ins = e_req.instruction;
  assign opc = ins[6:0];
  assign f3  = ins[14:12];
  assign rd  = ins[11:7];
  assign rs1 = (e_req.req_type == REQ_READ) ? e_req.reg_index : ins[19:15];
  assign rs2 = ins[24:20];

  always_comb begin
    if (e_held) begin
      src_a = hold_a;
    end else if (m_valid && (m.rd == rs1)) begin
      src_a = m_val;
    end else if (byp1) begin
      src_a = byp_val;
    end else begin
      src_a = rv1 ? q1 : 32'd0;
    end
    if (e_held) begin
      src_b = hold_b;
    end else if (m_valid && (m.rd == rs2)) begin
      src_b = m_val;
    end else if (byp2) begin
      src_b = byp_val;
    end else begin
      src_b = rv2 ? q2 : 32'd0;
    end
  end

  assign imm_i = {{20{ins[31]}}, ins[31:20]};
  assign imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
  assign imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
  assign imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
  assign imm_u = {ins[31:12], 12'd0};

  assign alu_b   = (opc == OPC_ALUREG) ? src_b : imm_i;
  assign alu_alt = ins[30] && ((f3 == F3_SR) || (opc == OPC_ALUREG && f3 == F3_ADD));

  rvx_alu u_alu (
    .a(src_a), .b((opc == OPC_BRANCH) ? src_b : alu_b), .f3(f3), .alt(alu_alt),
    .y(alu_y), .cond(cond)
  );

  assign addr = src_a + ((opc == OPC_STORE) ? imm_s : imm_i);
  assign pc4  = pc + 32'd4;

  always_comb begin
    case (opc)
      OPC_BRANCH: tgt_imm = imm_b;
      OPC_JAL:    tgt_imm = imm_j;
      default:    tgt_imm = imm_u;
    endcase
  end

  assign tgt = pc + tgt_imm;

  // decode
  always_comb begin
    legal = 1'b1;
    wen   = 1'b0;
    wval  = alu_y;
    is_ld = 1'b0;
    is_st = 1'b0;
    jump  = 1'b0;
    br    = 1'b0;
    next  = pc4;
    case (opc)
      OPC_BRANCH: begin
        legal = f3 inside {F3_BEQ, F3_BNE, F3_BLT, F3_BGE, F3_BLTU, F3_BGEU};
        br    = 1'b1;
        if (cond) begin
          next = tgt;
        end
      end
      OPC_ALUIMM, OPC_ALUREG: begin
        wen = 1'b1;
      end
      OPC_LOAD: begin
        legal = f3 inside {F3_LB, F3_LH, F3_LW, F3_LBU, F3_LHU};
        wen   = 1'b1;
        is_ld = 1'b1;
      end
      OPC_STORE: begin
        legal = f3 inside {F3_SB, F3_SH, F3_SW};
        is_st = 1'b1;
      end
      OPC_JAL: begin
        wen  = 1'b1;
        wval = pc4;
        next = tgt;
        jump = 1'b1;
      end
      OPC_JALR: begin
        legal = f3 == F3_JALR;
        wen   = 1'b1;
        wval  = pc4;
        next  = {addr[31:1], 1'b0};
        jump  = 1'b1;
      end
      OPC_LUI: begin
        wen  = 1'b1;
        wval = imm_u;
      end
      OPC_AUIPC: begin
        wen  = 1'b1;
        wval = tgt;
      end
      default: begin
        legal = 1'b0;
      end
    endcase
  end

  assign is_exec = e_req.req_type == REQ_EXEC;
  assign do_ins  = is_exec && legal;
  assign wen_fin = do_ins && wen && (rd != 5'd0);

  // data memory addressing
  generate
    if ((1 << AW) == DATA_WORDS) begin : g_pow2
      assign widx = addr[AW+1:2];
      assign pidx = AW'(e_req.mem_word_index);
    end else begin : g_mod
      // sum the residue of each set index bit, then one parallel reduction
      function automatic logic [AW-1:0] mod_words(logic [29:0] x);
        logic [AW+4:0] s;
        logic [AW-1:0] r;
        s = '0;
        for (int j = 0; j < 30; j++) begin
          if (x[j]) begin
            s = s + (AW+5)'((64'd1 << j) % DATA_WORDS);
          end
        end
        r = s[AW-1:0];
        for (int k = 1; k < 30; k++) begin
          if (s >= (AW+5)'(k * DATA_WORDS)) begin
            r = AW'(s - (AW+5)'(k * DATA_WORDS));
          end
        end
        return r;
      endfunction
      assign widx = mod_words(addr[31:2]);
      assign pidx = mod_words({18'd0, e_req.mem_word_index});
    end
  endgenerate

  always_comb begin
    case (f3)
      F3_SB: begin
        st_be   = 4'b0001 << addr[1:0];
        st_data = {4{src_b[7:0]}};
      end
      F3_SH: begin
        st_be   = addr[1] ? 4'b1100 : 4'b0011;
        st_data = {2{src_b[15:0]}};
      end
      default: begin
        st_be   = 4'b1111;
        st_data = src_b;
      end
    endcase
  end

  assign d_we    = e_fire && ((do_ins && is_st) || (e_req.req_type == REQ_PRELOAD));
  assign d_be    = (e_req.req_type == REQ_PRELOAD) ? 4'hF : st_be;
  assign d_waddr = (e_req.req_type == REQ_PRELOAD) ? pidx : widx;
  assign d_wdata = (e_req.req_type == REQ_PRELOAD) ? e_req.mem_word_data : st_data;

  rvx_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_dmem (
    .clk(clk), .we(d_we), .be(d_be), .waddr(d_waddr), .wdata(d_wdata),
    .re(e_fire && do_ins && is_ld), .raddr(widx), .rdata(dq)
  );

endmodule

`default_nettype wire

>>> dv/rvx_core_checker.sv
// rvx_core_checker: watches the request and response channels of the rv32i core,
// predicts each response from its own copy of pc, registers and data memory
// depends on rvx_pkg and rvx_stream_if
`timescale 1ns / 1ps
`default_nettype none

module rvx_core_checker #(
  parameter int DATA_WORDS = 4096
) (
  input wire logic clk,
  input wire logic rst,
  rvx_req_if.sink  req,
  rvx_rsp_if.sink  rsp,
  output int       fail_count,
  output int       pending
);
  import rvx_pkg::*;

  logic [31:0] pc_q;
  logic [31:0] regs_q [32];
  logic [31:0] dmem_q [DATA_WORDS];
  rsp_t        rsp_queue [$];

  function automatic logic signed_lt(logic [31:0] a, logic [31:0] b);
    return $signed(a) < $signed(b);
  endfunction

  function automatic logic [31:0] alu_model(logic [31:0] a, logic [31:0] b, logic [2:0] f3,
                                            logic alt);
    case (f3)
      F3_ADD:  return alt ? a - b : a + b;
      F3_SLL:  return a << b[4:0];
      F3_SLT:  return {31'd0, signed_lt(a, b)};
      F3_SLTU: return {31'd0, a < b};
      F3_XOR:  return a ^ b;
      F3_SR:   return alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
      F3_OR:   return a | b;
      default: return a & b;
    endcase
  endfunction

  function automatic int word_of(logic [31:0] addr);
    return int'((addr >> 2) % DATA_WORDS);
  endfunction

  task automatic write_reg(logic [4:0] rd, logic [31:0] v);
    if (rd != 5'd0) regs_q[rd] = v;
  endtask

  task automatic predict_response(req_t r);
    rsp_t        o;
    logic [31:0] ins, a, b, imm_i, imm, addr, nxt, w, v, m;
    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [4:0]  rd;
    logic        alt, cond, bad;
    int          wi, sh;
    o = '0;
    o.next_pc = pc_q;
    if (r.req_type == REQ_PRELOAD) begin
      dmem_q[int'(r.mem_word_index) % DATA_WORDS] = r.mem_word_data;
    end else if (r.req_type == REQ_READ) begin
      o.read_value = regs_q[r.reg_index];
    end else if (r.req_type == REQ_EXEC) begin
      ins = r.instruction;
      opc = ins[6:0];
      f3 = ins[14:12];
      rd = ins[11:7];
      a = regs_q[ins[19:15]];
      b = regs_q[ins[24:20]];
      alt = ins[30];
      imm_i = {{20{ins[31]}}, ins[31:20]};
      nxt = pc_q + 32'd4;
      bad = 1'b0;
      cond = 1'b0;
      case (opc)
        OPC_BRANCH: begin
          imm = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
          case (f3)
            F3_BEQ:  cond = a == b;
            F3_BNE:  cond = a != b;
            F3_BLT:  cond = signed_lt(a, b);
            F3_BGE:  cond = !signed_lt(a, b);
            F3_BLTU: cond = a < b;
            F3_BGEU: cond = a >= b;
            default: bad = 1'b1;
          endcase
          if (cond) nxt = pc_q + imm;
        end
        OPC_ALUIMM: begin
          if (f3 == F3_SLL || f3 == F3_SR)
            write_reg(rd, alu_model(a, {27'd0, ins[24:20]}, f3, f3 == F3_SR && alt));
          else
            write_reg(rd, alu_model(a, imm_i, f3, 1'b0));
        end
        OPC_LOAD: begin
          addr = a + imm_i;
          w = dmem_q[word_of(addr)];
          v = '0;
          case (f3)
            F3_LB:  begin v = (w >> (addr[1:0] * 8)) & 32'hFF; v = {{24{v[7]}}, v[7:0]}; end
            F3_LH:  begin v = (w >> (addr[1] * 16)) & 32'hFFFF; v = {{16{v[15]}}, v[15:0]}; end
            F3_LW:  v = w;
            F3_LBU: v = (w >> (addr[1:0] * 8)) & 32'hFF;
            F3_LHU: v = (w >> (addr[1] * 16)) & 32'hFFFF;
            default: bad = 1'b1;
          endcase
          if (!bad) write_reg(rd, v);
        end
        OPC_STORE: begin
          imm = {{20{ins[31]}}, ins[31:25], ins[11:7]};
          addr = a + imm;
          wi = word_of(addr);
          sh = 0;
          m = '1;
          case (f3)
            F3_SB:   begin sh = addr[1:0] * 8; m = 32'hFF << sh; end
            F3_SH:   begin sh = addr[1] * 16; m = 32'hFFFF << sh; end
            F3_SW:   ;
            default: bad = 1'b1;
          endcase
          if (!bad) dmem_q[wi] = (dmem_q[wi] & ~m) | ((b << sh) & m);
        end
        OPC_ALUREG: write_reg(rd, alu_model(a, b, f3, (f3 == F3_ADD || f3 == F3_SR) && alt));
        OPC_JAL: begin
          imm = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
          write_reg(rd, pc_q + 32'd4);
          nxt = pc_q + imm;
          cond = 1'b1;
        end
        OPC_JALR: begin
          if (f3 != F3_JALR) bad = 1'b1;
          else begin
            nxt = (a + imm_i) & ~32'd1;
            write_reg(rd, pc_q + 32'd4);
            cond = 1'b1;
          end
        end
        OPC_LUI:   write_reg(rd, {ins[31:12], 12'd0});
        OPC_AUIPC: write_reg(rd, pc_q + {ins[31:12], 12'd0});
        default:   bad = 1'b1;
      endcase
      if (bad) o.illegal = 1'b1;
      else begin
        pc_q = nxt;
        o.next_pc = nxt;
        o.branch_taken = cond;
      end
    end
    rsp_queue.push_back(o);
  endtask

  always @(posedge clk) begin
    rsp_t e;
    if (rst) begin
      pc_q = '0;
      foreach (regs_q[i]) regs_q[i] = '0;
      rsp_queue.delete();
      fail_count = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (rsp_queue.size() == 0) begin
          $display("%0t: response with none expected, actual %h", $realtime, rsp.data);
          fail_count++;
        end else begin
          e = rsp_queue.pop_front();
          if (rsp.data.next_pc !== e.next_pc)
            $display("%0t: next_pc expected %h actual %h", $realtime, e.next_pc,
                     rsp.data.next_pc);
          if (rsp.data.read_value !== e.read_value)
            $display("%0t: read_value expected %h actual %h", $realtime, e.read_value,
                     rsp.data.read_value);
          if (rsp.data.branch_taken !== e.branch_taken)
            $display("%0t: branch_taken expected %b actual %b", $realtime, e.branch_taken,
                     rsp.data.branch_taken);
          if (rsp.data.illegal !== e.illegal)
            $display("%0t: illegal expected %b actual %b", $realtime, e.illegal,
                     rsp.data.illegal);
          if (rsp.data !== e) fail_count++;
        end
      end
      if (req.valid && req.ready) predict_response(req.data);
    end
    pending = rsp_queue.size();
  end

endmodule

`default_nettype wire

>>> dv/testbench.sv
// testbench: drives directed and random rv32i requests into the execute core
// and gives the verdict from the checker's failure count
// depends on rvx_pkg, rvx_stream_if, rv32i_execute_core_unit, rvx_core_checker
`timescale 1ns / 1ps
`default_nettype none

module testbench;
  import rvx_pkg::*;

  localparam int WATCHDOG = 2000;
  localparam int NUM_RANDOM = 1600;
  localparam int NUM_WORDS = 64;

  logic clk = 0;
  logic rst = 1;
  int   fail_count, pending, idle_cycles;
  bit   calm = 0;

  rvx_req_if req ();
  rvx_rsp_if rsp ();

  rv32i_execute_core_unit i_dut (.clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source));
  rvx_core_checker i_checker (.clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.sink),
                              .fail_count(fail_count), .pending(pending));

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // sink-side stalls
  initial begin
    int n;
    rsp.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 6);
        rsp.ready <= 0;
        repeat (n) @(posedge clk);
      end
      rsp.ready <= 1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("testbench: errors");
      $finish;
    end
  end

  task automatic send_request(req_t r);
    int n;
    if (!calm && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 6);
      req.valid <= 0;
      repeat (n) @(posedge clk);
    end
    req.valid <= 1;
    req.data <= r;
    do @(posedge clk); while (!req.ready);
  endtask

  function automatic req_t exec_req(logic [31:0] ins);
    req_t r;
    r = '0;
    r.req_type = REQ_EXEC;
    r.instruction = ins;
    r.mem_word_index = 12'($urandom);
    r.mem_word_data = $urandom;
    r.reg_index = 5'($urandom);
    return r;
  endfunction

  function automatic logic [31:0] i_type(logic [6:0] opc, logic [2:0] f3, logic [4:0] rd,
                                         logic [4:0] rs1, logic [11:0] imm);
    return {imm, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] r_type(logic [2:0] f3, logic alt, logic [4:0] rd,
                                         logic [4:0] rs1, logic [4:0] rs2);
    return {1'b0, alt, 5'd0, rs2, rs1, f3, rd, OPC_ALUREG};
  endfunction

  // memory ops use x1 as base, which is never written and so stays zero; offsets stay in the preloaded window
  function automatic logic [31:0] random_instruction();
    logic [31:0] ins;
    logic [2:0]  f3;
    ins = $urandom;
    f3 = ins[14:12];
    case ($urandom_range(0, 11))
      0:  ins[6:0] = OPC_ALUIMM;
      1:  ins[6:0] = OPC_ALUREG;
      2:  ins[6:0] = OPC_LUI;
      3:  ins[6:0] = OPC_AUIPC;
      4:  ins[6:0] = OPC_BRANCH;
      5:  ins[6:0] = OPC_JAL;
      6:  begin ins[6:0] = OPC_JALR; if ($urandom_range(0, 7) != 0) ins[14:12] = F3_JALR; end
      7, 8: begin
        ins = i_type(OPC_LOAD, f3, 5'($urandom_range(2, 31)), 5'd1,
                     12'($urandom_range(0, NUM_WORDS * 4 - 1)));
      end
      9, 10: begin
        ins = i_type(OPC_STORE, f3, 5'd0, 5'd1, 12'($urandom_range(0, NUM_WORDS * 4 - 1)));
        ins[24:20] = 5'($urandom);
        ins[11:7] = ins[24:20];
        ins[24:20] = 5'($urandom);
      end
      // loads only through the x1 window
      default: if (ins[6:0] == OPC_LOAD) ins[6:0] = OPC_LUI;
    endcase
    // keep x1 as the zero memory base
    if (ins[6:0] != OPC_STORE && ins[6:0] != OPC_BRANCH && ins[11:7] == 5'd1)
      ins[11:7] = 5'd2;
    return ins;
  endfunction

  initial begin
    req_t r;
    req.valid <= 1'b0;
    req.data <= '0;
    repeat (5) @(posedge clk);
    rst <= 0;
    // fill a small memory window so every load hits written words
    for (int i = 0; i < NUM_WORDS; i++) begin
      r = '0;
      r.req_type = REQ_PRELOAD;
      r.mem_word_index = 12'(i);
      r.mem_word_data = (i == 0) ? 32'hFFFF_FFFF : $urandom;
      send_request(r);
    end
    r = '0;
    r.req_type = REQ_PRELOAD;
    r.mem_word_index = 12'hFFF;
    r.mem_word_data = 32'h8000_0001;
    send_request(r);
    // directed
    send_request(exec_req(i_type(OPC_ALUIMM, F3_ADD, 5'd3, 5'd0, 12'h800)));
    send_request(exec_req(i_type(OPC_ALUIMM, F3_ADD, 5'd4, 5'd0, 12'h7FF)));
    send_request(exec_req(i_type(OPC_ALUIMM, F3_SR, 5'd5, 5'd3, 12'h41F)));
    send_request(exec_req(i_type(OPC_ALUIMM, F3_SLL, 5'd6, 5'd4, 12'h01F)));
    send_request(exec_req(r_type(F3_ADD, 1'b1, 5'd7, 5'd0, 5'd3)));
    send_request(exec_req(r_type(F3_SLT, 1'b0, 5'd8, 5'd3, 5'd4)));
    send_request(exec_req(r_type(F3_SLTU, 1'b0, 5'd9, 5'd3, 5'd4)));
    send_request(exec_req(r_type(F3_SR, 1'b1, 5'd10, 5'd3, 5'd6)));
    send_request(exec_req(i_type(OPC_LOAD, F3_LB, 5'd11, 5'd0, 12'd3)));
    send_request(exec_req(i_type(OPC_LOAD, F3_LHU, 5'd12, 5'd0, 12'd2)));
    send_request(exec_req(i_type(OPC_LOAD, F3_LW, 5'd13, 5'd0, 12'hFFC)));
    send_request(exec_req(i_type(OPC_LOAD, F3_LH, 5'd14, 5'd0, 12'd3)));
    send_request(exec_req(i_type(OPC_LOAD, 3'd3, 5'd15, 5'd0, 12'd0)));
    send_request(exec_req({7'd0, 5'd3, 5'd0, F3_SB, 5'd1, OPC_STORE}));
    send_request(exec_req({7'd0, 5'd3, 5'd0, 3'd5, 5'd1, OPC_STORE}));
    send_request(exec_req({1'b1, 6'h3F, 5'd0, 5'd0, F3_BEQ, 4'hE, 1'b1, OPC_BRANCH}));
    send_request(exec_req({1'b0, 6'd0, 5'd0, 5'd0, 3'd2, 4'd4, 1'b0, OPC_BRANCH}));
    send_request(exec_req(32'hFFFF_F16F));
    send_request(exec_req(i_type(OPC_JALR, F3_JALR, 5'd0, 5'd4, 12'h001)));
    send_request(exec_req(i_type(OPC_JALR, 3'd1, 5'd0, 5'd4, 12'h001)));
    send_request(exec_req({20'hFFFFF, 5'd16, OPC_LUI}));
    send_request(exec_req({20'h80000, 5'd17, OPC_AUIPC}));
    send_request(exec_req(32'hFFFF_FFFF));
    r = '0;
    r.req_type = REQ_UNUSED;
    r.instruction = '1;
    r.mem_word_data = '1;
    r.mem_word_index = '1;
    r.reg_index = '1;
    send_request(r);
    r = '0;
    r.req_type = REQ_READ;
    r.reg_index = 5'd31;
    send_request(r);
    // wait for the core to drain before the random part
    req.valid <= 0;
    do @(posedge clk); while (pending != 0);
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == NUM_RANDOM - 200) calm = 1;
      case ($urandom_range(0, 19))
        0: begin
          r = '0;
          r.req_type = REQ_PRELOAD;
          r.mem_word_index = ($urandom_range(0, 3) == 0) ? 12'($urandom)
                                                          : 12'($urandom_range(0, NUM_WORDS - 1));
          r.mem_word_data = $urandom;
          r.reg_index = 5'($urandom);
          r.instruction = $urandom;
        end
        1, 2: begin
          r = exec_req(32'h0);
          r.req_type = REQ_READ;
        end
        3: begin
          r = exec_req(32'h0);
          r.req_type = REQ_UNUSED;
        end
        default: r = exec_req(random_instruction());
      endcase
      send_request(r);
    end
    req.valid <= 0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
    if (fail_count == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end
endmodule

`default_nettype wire

>>> rv32i_execute_core_unit.f
design/rvx_pkg.sv
design/rvx_stream_if.sv
design/rvx_ram.sv
design/rvx_alu.sv
design/rvx_load_align.sv
design/rv32i_execute_core_unit.sv
dv/rvx_core_checker.sv
dv/testbench.sv
